// ===== design/kmrb_pkg.sv =====
// ---------------------------------------------------------------------------
// Keyboard matrix report builder package
// Shared widths, codes and payload types for the report builder.
// ---------------------------------------------------------------------------
package kmrb_pkg;

  // Field widths fixed by the request and report formats.
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int SAMPLE_W   = 8;
  localparam int CODE_W     = 8;
  localparam int LAYER_W    = 2;
  localparam int CNT_W      = 3;

  // Number of key slots carried in one report.
  localparam int REPORT_SLOTS = 6;

  // Default geometry handed to the top level parameters.
  localparam int ROWS_DEF      = 8;
  localparam int COLS_DEF      = 8;
  localparam int KEY_SLOTS_DEF = 6;

  // Keymap layers.
  localparam logic [LAYER_W-1:0] MAP_BASE = 2'd0;
  localparam logic [LAYER_W-1:0] MAP_UP   = 2'd1;
  localparam logic [LAYER_W-1:0] MAP_DOWN = 2'd2;
  localparam int                 LAYERS   = 3;

  // Request commands.
  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_UP_KEY   = 1'b0;
  localparam logic REG_DOWN_KEY = 1'b1;

  // First modifier code; the eight modifiers share its upper five bits.
  localparam logic [CODE_W-1:0] MOD_FIRST = 8'hE0;

  // Reset values of the layer code registers.
  localparam logic [CODE_W-1:0] UP_KEY_CODE_RST   = 8'd240;
  localparam logic [CODE_W-1:0] DOWN_KEY_CODE_RST = 8'd241;

  // One request: a row scan or a keymap write.
  typedef struct packed {
    logic                  command;
    logic [ROW_W-1:0]      row_index;
    logic [SAMPLE_W-1:0]   early_sample;
    logic [SAMPLE_W-1:0]   late_sample;
    logic                  final_row;
    logic [LAYER_W-1:0]    map_layer;
    logic [COL_W-1:0]      map_column;
    logic [CODE_W-1:0]     map_code;
  } req_t;

  // One keyboard report.
  typedef struct packed {
    logic [CODE_W-1:0] modifier_mask;
    logic [CODE_W-1:0] key_slot_0;
    logic [CODE_W-1:0] key_slot_1;
    logic [CODE_W-1:0] key_slot_2;
    logic [CODE_W-1:0] key_slot_3;
    logic [CODE_W-1:0] key_slot_4;
    logic [CODE_W-1:0] key_slot_5;
    logic [CNT_W-1:0]  key_total;
  } report_t;

  // Keymap read address driven by the column sequencer.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } map_rd_t;

  // Sequencer controls for the report accumulator.
  typedef struct packed {
    logic key_valid;  // keymap read data belongs to a pressed key
    logic emit;       // publish the report and start a new scan
  } acc_ctrl_t;

endpackage

// ===== design/kmrb_keymap.sv =====
// ---------------------------------------------------------------------------
// Keymap memory
// Three layers of ROWS x COLS key codes, one write port and two registered
// read ports (base layer and the selected alternate layer).
// ---------------------------------------------------------------------------
module kmrb_keymap
  import kmrb_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [LAYER_W-1:0]  wr_layer,
  input  logic [ROW_W-1:0]    wr_row,
  input  logic [COL_W-1:0]    wr_col,
  input  logic [CODE_W-1:0]   wr_data,
  input  map_rd_t             rd,
  input  logic [LAYER_W-1:0]  alt_layer,
  output logic [CODE_W-1:0]   base_code,
  output logic [CODE_W-1:0]   alt_code
);

  localparam int MAP_DEPTH = LAYERS * ROWS * COLS;
  localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  logic [CODE_W-1:0] mem [MAP_DEPTH];

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] alt_addr;
  logic              wr_ok;

  // Flat addresses: (layer * ROWS + row) * COLS + col.
  assign wr_addr   = ADDR_W'((int'(wr_layer) * ROWS + int'(wr_row)) * COLS + int'(wr_col));
  assign base_addr = ADDR_W'((int'(MAP_BASE) * ROWS + int'(rd.row)) * COLS + int'(rd.col));
  assign alt_addr  = ADDR_W'((int'(alt_layer) * ROWS + int'(rd.row)) * COLS + int'(rd.col));

  // Writes outside the populated layers, rows or columns are dropped.
  assign wr_ok = (int'(wr_layer) < LAYERS) && (int'(wr_row) < ROWS) &&
                 (int'(wr_col) < COLS);

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Both read ports are registered.
  always_ff @(posedge clk) begin
    base_code <= mem[base_addr];
    alt_code  <= mem[alt_addr];
  end

endmodule

// ===== design/kmrb_col_seq.sv =====
// ---------------------------------------------------------------------------
// Column sequencer
// Shifts the pressed-key bits of one row out one column per cycle, drives the
// keymap read address and tells the accumulator when to take a key or emit.
// ---------------------------------------------------------------------------
module kmrb_col_seq
  import kmrb_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                scan_go,
  input  logic [ROW_W-1:0]    row_index,
  input  logic [SAMPLE_W-1:0] early_sample,
  input  logic [SAMPLE_W-1:0] late_sample,
  input  logic                final_row,
  output logic                busy,
  output map_rd_t             rd,
  output acc_ctrl_t           ctrl
);

  localparam int SCAN_COLS = (COLS < SAMPLE_W) ? COLS : SAMPLE_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [ROW_W-1:0]    row_q;
  logic                final_q;
  logic [SAMPLE_W-1:0] pressed_sh;
  logic [COL_W-1:0]    col_cnt;
  logic                key_valid;
  logic                last_col;
  logic                row_ok;

  assign row_ok   = int'(row_index) < ROWS;
  assign last_col = (col_cnt == COL_W'(SCAN_COLS - 1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (scan_go) state_next = S_SCAN;
      S_SCAN:   if (last_col) state_next = S_DRAIN;
      S_DRAIN:  state_next = final_q ? S_FINISH : S_IDLE;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Row capture and the column shift register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && scan_go) begin
      row_q      <= row_index;
      final_q    <= final_row;
      pressed_sh <= row_ok ? (early_sample & late_sample) : '0;
      col_cnt    <= '0;
    end else if (state == S_SCAN) begin
      pressed_sh <= pressed_sh >> 1;
      col_cnt    <= col_cnt + COL_W'(1);
    end
  end

  // A key is pending in the cycle its keymap read data comes back.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else begin
      key_valid <= (state == S_SCAN) && pressed_sh[0];
    end
  end

  assign busy           = (state != S_IDLE);
  assign rd.row         = row_q;
  assign rd.col         = col_cnt;
  assign ctrl.key_valid = key_valid;
  assign ctrl.emit      = (state == S_FINISH);

endmodule

// ===== design/kmrb_report_acc.sv =====
// ---------------------------------------------------------------------------
// Report accumulator
// Classifies each pressed key, gathers modifiers, layer keys and key slots
// over a scan, and registers the finished report.
// ---------------------------------------------------------------------------
module kmrb_report_acc
  import kmrb_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  acc_ctrl_t          ctrl,
  input  logic [CODE_W-1:0]  base_code,
  input  logic [CODE_W-1:0]  alt_code,
  input  logic [CODE_W-1:0]  up_key_code,
  input  logic [CODE_W-1:0]  down_key_code,
  output logic [LAYER_W-1:0] alt_layer,
  output report_t            report,
  output logic               done
);

  logic [CODE_W-1:0] slot_store [REPORT_SLOTS];
  logic [CNT_W-1:0]  slot_count;
  logic [CODE_W-1:0] modifier_accum;
  logic              up_seen;
  logic              down_seen;
  logic              up_active;
  logic              down_active;
  logic              is_mod;
  logic              has_room;
  logic [CODE_W-1:0] key_code;

  assign is_mod    = (base_code[CODE_W-1:3] == MOD_FIRST[CODE_W-1:3]);
  assign has_room  = (slot_count < CNT_W'(KEY_SLOTS));
  assign key_code  = (up_active || down_active) ? alt_code : base_code;
  assign alt_layer = up_active ? MAP_UP : MAP_DOWN;

  // Scan accumulators: modifiers, layer keys and ordinary key slots.
  always_ff @(posedge clk) begin
    if (rst || ctrl.emit) begin
      for (int k = 0; k < REPORT_SLOTS; k++) begin
        slot_store[k] <= '0;
      end
      slot_count     <= '0;
      modifier_accum <= '0;
      up_seen        <= 1'b0;
      down_seen      <= 1'b0;
    end else if (ctrl.key_valid) begin
      if (is_mod) begin
        modifier_accum[base_code[2:0]] <= 1'b1;
      end else if (base_code == up_key_code) begin
        up_seen <= 1'b1;
      end else if (base_code == down_key_code) begin
        down_seen <= 1'b1;
      end else if (has_room) begin
        for (int k = 0; k < REPORT_SLOTS; k++) begin
          if (slot_count == CNT_W'(k)) begin
            slot_store[k] <= key_code;
          end
        end
        slot_count <= slot_count + CNT_W'(1);
      end
    end
  end

  // Layer choice for the next scan comes from the layer keys of this one.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_active   <= 1'b0;
      down_active <= 1'b0;
    end else if (ctrl.emit) begin
      up_active   <= up_seen;
      down_active <= down_seen;
    end
  end

  // Report register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      report.modifier_mask <= modifier_accum;
      report.key_slot_0    <= slot_store[0];
      report.key_slot_1    <= slot_store[1];
      report.key_slot_2    <= slot_store[2];
      report.key_slot_3    <= slot_store[3];
      report.key_slot_4    <= slot_store[4];
      report.key_slot_5    <= slot_store[5];
      report.key_total     <= slot_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
    end
  end

endmodule

// ===== design/key_matrix_report_builder_top.sv =====
// ---------------------------------------------------------------------------
// Keyboard matrix report builder
// Builds a six-key keyboard report from debounced row scans and a
// three-layer keymap that is loaded through the request channel.
// ---------------------------------------------------------------------------
//
//  Channel  | Signals                        | Handshake
//  ---------+--------------------------------+-------------------------------
//  request  | req                            | taken when start && !busy
//  report   | report                         | valid for one cycle with done
//  config   | cfg_we, cfg_index, cfg_data    | written when cfg_we is high
//
// A keymap write leaves busy low. A row scan walks min(COLS, 8) columns,
// one per cycle, through the keymap read ports; busy stays high through
// the column walk and the drain state, and on the final row also through
// the finish state from which done is registered, so busy is already low
// in the done cycle. The receiver cannot stall.
// Reset returns both layer codes to their defaults, clears sequencer and
// accumulator state; the keymap itself holds its contents until written.
//
module key_matrix_report_builder_top
  import kmrb_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int COLS      = COLS_DEF,
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output report_t           report,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CODE_W-1:0] cfg_data
);

  localparam int SCAN_COLS = (COLS < SAMPLE_W) ? COLS : SAMPLE_W;

  logic               accept;
  logic               scan_go;
  logic               map_wr;
  logic [CODE_W-1:0]  up_key_code;
  logic [CODE_W-1:0]  down_key_code;
  map_rd_t            rd;
  acc_ctrl_t          ctrl;
  logic [LAYER_W-1:0] alt_layer;
  logic [CODE_W-1:0]  base_code;
  logic [CODE_W-1:0]  alt_code;

  assign accept  = start && !busy;
  assign scan_go = accept && (req.command == CMD_SCAN);
  assign map_wr  = accept && (req.command == CMD_WRITE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_key_code   <= UP_KEY_CODE_RST;
      down_key_code <= DOWN_KEY_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UP_KEY:   up_key_code   <= cfg_data;
        REG_DOWN_KEY: down_key_code <= cfg_data;
        default:      up_key_code   <= up_key_code;
      endcase
    end
  end

  kmrb_keymap #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_keymap (
    .clk      (clk),
    .wr_en    (map_wr),
    .wr_layer (req.map_layer),
    .wr_row   (req.row_index),
    .wr_col   (req.map_column),
    .wr_data  (req.map_code),
    .rd       (rd),
    .alt_layer(alt_layer),
    .base_code(base_code),
    .alt_code (alt_code)
  );

  kmrb_col_seq #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_col_seq (
    .clk         (clk),
    .rst         (rst),
    .scan_go     (scan_go),
    .row_index   (req.row_index),
    .early_sample(req.early_sample),
    .late_sample (req.late_sample),
    .final_row   (req.final_row),
    .busy        (busy),
    .rd          (rd),
    .ctrl        (ctrl)
  );

  kmrb_report_acc #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_report_acc (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .base_code    (base_code),
    .alt_code     (alt_code),
    .up_key_code  (up_key_code),
    .down_key_code(down_key_code),
    .alt_layer    (alt_layer),
    .report       (report),
    .done         (done)
  );

  // A report is only published once the sequencer has gone idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("report strobe while the sequencer is busy");

  // A keymap write never occupies the sequencer.
  assert property (@(posedge clk) disable iff (rst) map_wr |=> !busy)
    else $error("keymap write left the block busy");

  // A final row publishes its report after the fixed column walk.
  assert property (@(posedge clk) disable iff (rst)
      (scan_go && req.final_row) |-> ##(SCAN_COLS + 3) done)
    else $error("final row did not produce a report");

  // A row that is not final publishes nothing.
  assert property (@(posedge clk) disable iff (rst)
      (scan_go && !req.final_row) |-> ##(SCAN_COLS + 3) !done)
    else $error("report produced for a row that is not final");

endmodule

// ===== tb/sv/key_matrix_report_builder_top_tb.sv =====
// ---------------------------------------------------------------------------
// Keyboard matrix report builder testbench
// Loads the whole keymap and runs directed scans through the modifier, layer
// and overflow paths. Random scans then follow under several layer-code
// settings and sender idle patterns. Every report is compared field by field
// with a shadow model of the scan state.
// ---------------------------------------------------------------------------
module key_matrix_report_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmrb_pkg::*;

  // A layer value that the keymap does not have; writes to it are dropped.
  localparam logic [LAYER_W-1:0] MAP_NONE = 2'd3;

  localparam int REQ_W         = $bits(req_t);
  localparam int SETTLE_CYCLES = COLS_DEF + 4;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int PHASES        = 8;
  localparam int PRINT_LIMIT   = 50;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  req_t              req = '0;
  logic              done;
  report_t           report;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_UP_KEY;
  logic [CODE_W-1:0] cfg_data = '0;

  // Shadow copy of the keymap, the scan accumulators and the layer codes.
  logic [CODE_W-1:0] keymap_sh [LAYERS][ROWS_DEF][COLS_DEF];
  logic [CODE_W-1:0] slots_sh [REPORT_SLOTS];
  int                slot_cnt_sh;
  logic [CODE_W-1:0] mods_sh;
  bit                up_seen_sh, down_seen_sh, up_on_sh, down_on_sh;
  logic [CODE_W-1:0] up_code_sh, down_code_sh;

  report_t    reports_due[$];
  int         errors = 0;
  int         requests_sent = 0;
  int         reports_seen = 0;
  int         settings_run = 0;
  int         gap_pct = 0;
  bit         quiet = 1'b0;
  idle_mode_e idle_mode = IDLE_NONE;

  key_matrix_report_builder_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .report    (report),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or reports go missing.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Print one mismatch line (up to a limit) and count it.
  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      log_mismatch(what, got, want);
    end
  endtask

  function automatic void reset_shadow();
    slots_sh = '{default: '0};
    slot_cnt_sh = 0;
    mods_sh = '0;
    up_seen_sh = 1'b0;
    down_seen_sh = 1'b0;
    up_on_sh = 1'b0;
    down_on_sh = 1'b0;
    up_code_sh = UP_KEY_CODE_RST;
    down_code_sh = DOWN_KEY_CODE_RST;
  endfunction

  // One pressed key: modifiers and layer keys come from the base code, and
  // an ordinary key takes its code from the layer chosen by the last scan.
  function automatic void press_key(int row, int col);
    logic [CODE_W-1:0] base;
    base = keymap_sh[MAP_BASE][row][col];
    if (base[CODE_W-1:3] == MOD_FIRST[CODE_W-1:3]) begin
      mods_sh[base[2:0]] = 1'b1;
    end else if (base == up_code_sh) begin
      up_seen_sh = 1'b1;
    end else if (base == down_code_sh) begin
      down_seen_sh = 1'b1;
    end else if (slot_cnt_sh < KEY_SLOTS_DEF) begin
      if (up_on_sh) begin
        slots_sh[slot_cnt_sh] = keymap_sh[MAP_UP][row][col];
      end else if (down_on_sh) begin
        slots_sh[slot_cnt_sh] = keymap_sh[MAP_DOWN][row][col];
      end else begin
        slots_sh[slot_cnt_sh] = base;
      end
      slot_cnt_sh++;
    end
  endfunction

  // Advance the shadow state by one accepted request and queue the report
  // that a final row produces.
  function automatic void compute_report(req_t r);
    report_t rep;
    logic [SAMPLE_W-1:0] pressed;
    int c;
    if (r.command == CMD_WRITE) begin
      if (r.map_layer < LAYERS) begin
        keymap_sh[r.map_layer][r.row_index][r.map_column] = r.map_code;
      end
      return;
    end
    pressed = r.early_sample & r.late_sample;
    for (c = 0; c < COLS_DEF; c++) begin
      if (pressed[c]) begin
        press_key(r.row_index, c);
      end
    end
    if (!r.final_row) begin
      return;
    end
    rep.modifier_mask = mods_sh;
    rep.key_slot_0 = slots_sh[0];
    rep.key_slot_1 = slots_sh[1];
    rep.key_slot_2 = slots_sh[2];
    rep.key_slot_3 = slots_sh[3];
    rep.key_slot_4 = slots_sh[4];
    rep.key_slot_5 = slots_sh[5];
    rep.key_total = CNT_W'(slot_cnt_sh);
    reports_due.push_back(rep);
    up_on_sh = up_seen_sh;
    down_on_sh = down_seen_sh;
    up_seen_sh = 1'b0;
    down_seen_sh = 1'b0;
    slots_sh = '{default: '0};
    slot_cnt_sh = 0;
    mods_sh = '0;
  endfunction

  // Each report strobe is matched against the oldest report still due.
  always @(posedge clk) begin
    report_t want;
    if (!rst && done === 1'b1) begin
      reports_seen++;
      if (reports_due.size() == 0) begin
        log_mismatch("report with none due", report.key_total, 0);
      end else begin
        want = reports_due.pop_front();
        compare_field("modifier_mask", report.modifier_mask, want.modifier_mask);
        compare_field("key_slot_0", report.key_slot_0, want.key_slot_0);
        compare_field("key_slot_1", report.key_slot_1, want.key_slot_1);
        compare_field("key_slot_2", report.key_slot_2, want.key_slot_2);
        compare_field("key_slot_3", report.key_slot_3, want.key_slot_3);
        compare_field("key_slot_4", report.key_slot_4, want.key_slot_4);
        compare_field("key_slot_5", report.key_slot_5, want.key_slot_5);
        compare_field("key_total", report.key_total, want.key_total);
      end
    end
  end

  function automatic void set_idle_mode(idle_mode_e mode);
    idle_mode = mode;
    case (mode)
      IDLE_SENDER: begin
        gap_pct = 71;
      end
      IDLE_BOTH: begin
        gap_pct = 13;
      end
      // The report side has no stall input, so only the sender can idle.
      default: begin
        gap_pct = 0;
      end
    endcase
  endfunction

  // Present one request, hold it until it is taken, then maybe idle.
  // Start stays high when the next request follows straight away.
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
    end
    compute_report(r);
    requests_sent++;
    if (requests_sent % 40 == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
    end
    if (gap_pct != 0 && !quiet && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 6)) @(posedge clk);
    end
  endtask

  // Let every due report come back, then give a non-final scan time to end.
  task automatic wait_idle();
    int n;
    start <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && (busy !== 1'b0 || reports_due.size() != 0); n++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both layer codes are written on back-to-back cycles; call only when idle.
  task automatic set_layer_codes(input logic [CODE_W-1:0] up_code,
                                 input logic [CODE_W-1:0] down_code);
    cfg_we <= 1'b1;
    cfg_index <= REG_UP_KEY;
    cfg_data <= up_code;
    @(posedge clk);
    cfg_index <= REG_DOWN_KEY;
    cfg_data <= down_code;
    @(posedge clk);
    cfg_we <= 1'b0;
    up_code_sh = up_code;
    down_code_sh = down_code;
    settings_run++;
  endtask

  function automatic req_t random_request();
    req_t r;
    r = REQ_W'({$urandom(), $urandom()});
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sparse_byte(int pct);
    logic [SAMPLE_W-1:0] b;
    int i;
    for (i = 0; i < SAMPLE_W; i++) begin
      b[i] = ($urandom_range(0, 99) < pct);
    end
    return b;
  endfunction

  // Base entries lean toward modifiers and the current layer codes so that
  // every kind of key turns up in scans; the other layers take any code.
  function automatic logic [CODE_W-1:0] pick_code(logic [LAYER_W-1:0] layer);
    if (layer != MAP_BASE) begin
      return CODE_W'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 9))
      0, 1: return MOD_FIRST + CODE_W'($urandom_range(0, 7));
      2: return up_code_sh;
      3: return down_code_sh;
      default: return CODE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_entry(input logic [LAYER_W-1:0] layer, input int row, input int col,
                             input logic [CODE_W-1:0] code);
    req_t r;
    r = random_request();
    r.command = CMD_WRITE;
    r.map_layer = layer;
    r.row_index = ROW_W'(row);
    r.map_column = COL_W'(col);
    r.map_code = code;
    send_request(r);
  endtask

  task automatic scan_row(input int row, input logic [SAMPLE_W-1:0] early,
                          input logic [SAMPLE_W-1:0] late, input logic last);
    req_t r;
    r = random_request();
    r.command = CMD_SCAN;
    r.row_index = ROW_W'(row);
    r.early_sample = early;
    r.late_sample = late;
    r.final_row = last;
    send_request(r);
  endtask

  // Scan one row whose debounced keys are exactly the given set, with
  // bounce on either sample that the debounce must filter out.
  task automatic scan_bouncy_row(input int row, input logic [SAMPLE_W-1:0] keys,
                                 input logic last);
    logic [SAMPLE_W-1:0] noise;
    noise = SAMPLE_W'($urandom());
    scan_row(row, keys | (noise & sparse_byte(30)), keys | (~noise & sparse_byte(30)), last);
  endtask

  // Fill every entry of every layer so that no scan reads an unwritten one.
  task automatic test_keymap_load();
    int l, row, col;
    for (l = 0; l < LAYERS; l++) begin
      for (row = 0; row < ROWS_DEF; row++) begin
        for (col = 0; col < COLS_DEF; col++) begin
          write_entry(LAYER_W'(l), row, col, pick_code(LAYER_W'(l)));
        end
      end
    end
    wait_idle();
  endtask

  // Row 0 gets the extreme modifiers, both layer keys and four ordinary keys
  // with distinct codes on the up and down layers.
  task automatic test_directed_layers();
    int col;
    write_entry(MAP_BASE, 0, 0, MOD_FIRST);
    write_entry(MAP_BASE, 0, 1, MOD_FIRST + 8'd7);
    write_entry(MAP_BASE, 0, 2, up_code_sh);
    write_entry(MAP_BASE, 0, 3, down_code_sh);
    for (col = 4; col < COLS_DEF; col++) begin
      write_entry(MAP_BASE, 0, col, 8'h04 + CODE_W'(col));
      write_entry(MAP_UP, 0, col, 8'h1A + CODE_W'(col));
      write_entry(MAP_DOWN, 0, col, 8'h36 + CODE_W'(col));
    end
    // A write to the missing fourth layer must not land anywhere.
    write_entry(MAP_NONE, 0, 4, 8'hAA);

    // Keys on only one sample are bounce and give an empty report.
    scan_row(0, 8'hFF, 8'h00, 1'b1);
    scan_row(7, 8'h00, 8'hFF, 1'b1);
    // Everything held: both modifiers, both layer keys, four base codes.
    scan_row(0, 8'hFF, 8'hFF, 1'b1);
    // Both layers now active; the up layer wins.
    scan_row(0, 8'hF0, 8'hF0, 1'b1);
    // Down layer key alone, then eight ordinary keys on the down layer:
    // the last two overflow the slot list.
    scan_row(0, 8'h08, 8'h0F, 1'b1);
    scan_row(0, 8'hF0, 8'hF0, 1'b0);
    scan_row(0, 8'hF0, 8'hF0, 1'b1);
    wait_idle();
  endtask

  // Random traffic in phases, each with its own layer codes and idle mode.
  // Most of it is whole well-formed scans; the rest is keymap rewrites and
  // broken scans with random rows and stray final marks.
  task automatic test_random_scans();
    logic [CODE_W-1:0] up_list [PHASES] = '{8'd0, 8'd255, 8'hE3, 8'h29,
                                            8'd240, 8'd0, 8'd0, 8'd0};
    logic [CODE_W-1:0] down_list [PHASES] = '{8'd255, 8'd0, 8'hE4, 8'h29,
                                              8'd241, 8'd0, 8'd0, 8'd0};
    int p, row, n, count, roll, density;
    logic [LAYER_W-1:0] layer;
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p >= 6) begin
        set_layer_codes(CODE_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)));
      end else begin
        set_layer_codes(up_list[p], down_list[p]);
      end
      set_idle_mode(idle_mode_e'(p % 4));
      count = 0;
      while (count < RANDOM_ITEMS / PHASES) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          layer = LAYER_W'($urandom_range(0, 3));
          write_entry(layer, $urandom_range(0, ROWS_DEF - 1), $urandom_range(0, COLS_DEF - 1),
                      pick_code(layer));
          count++;
        end else if (roll < 85) begin
          case ($urandom_range(0, 3))
            0: density = 4;
            1: density = 10;
            2: density = 25;
            default: density = 70;
          endcase
          for (row = 0; row < ROWS_DEF; row++) begin
            scan_bouncy_row(row, sparse_byte(density), row == ROWS_DEF - 1);
          end
          count += ROWS_DEF;
        end else begin
          n = $urandom_range(1, 6);
          for (row = 0; row < n; row++) begin
            if ($urandom_range(0, 1) == 0) begin
              scan_bouncy_row($urandom_range(0, ROWS_DEF - 1), sparse_byte(20),
                              $urandom_range(0, 99) < 30);
            end else begin
              scan_row($urandom_range(0, ROWS_DEF - 1), SAMPLE_W'($urandom()),
                       SAMPLE_W'($urandom()), $urandom_range(0, 99) < 30);
            end
          end
          count += n;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    report_t left;
    reset_shadow();
    set_idle_mode(IDLE_NONE);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_keymap_load();
    test_directed_layers();
    test_random_scans();

    while (reports_due.size() != 0) begin
      left = reports_due.pop_front();
      log_mismatch("report never arrived", 0, left.key_total);
    end
    $display("Ran %0d requests and checked %0d reports.", requests_sent, reports_seen);
    $display("Covered %0d layer-code settings with and without sender idling.",
             settings_run);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
